/* rtl/ssc_pkg.sv */
package ssc_pkg;

   // Capacity of the stack and of the pop-order ring (both fill together).
   localparam int DEPTH = 1024;
   // Width of one pushed or popped value.
   localparam int VALUE_BITS = 16;

   localparam int IDX_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   // Stream payload widths: a request packs two values, padded to whole bytes.
   localparam int REQ_DATA_BITS = ((2 * VALUE_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = 8;

   // Decoupling queue between the front and the back end.
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_IDX_BITS = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

   typedef logic [VALUE_BITS-1:0] value_type;
   typedef logic [IDX_BITS-1:0] idx_type;
   typedef logic [CNT_BITS-1:0] cnt_type;

   localparam idx_type LAST_IDX = IDX_BITS'(DEPTH - 1);
   localparam cnt_type FULL_CNT = CNT_BITS'(DEPTH);

   typedef enum logic {
      ITEM_BODY,
      ITEM_LAST
   } item_kind_type;

   typedef struct packed {
      item_kind_type kind;
      value_type     pop_value;
      value_type     push_value;
   } item_type;

   // What the queue shows to the back end.
   typedef struct packed {
      logic     valid;
      item_type item;
   } fifo_head_type;

   typedef struct packed {
      logic too_long;
      logic sequence_valid;
   } result_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_CHECK,
      BACK_EMIT
   } back_state_type;

   function automatic idx_type ring_next(input idx_type idx);
      ring_next = (idx == LAST_IDX) ? '0 : idx + idx_type'(1);
   endfunction

endpackage

/* rtl/ssc_front.sv */
module ssc_front
   import ssc_pkg::*;
(
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   input  logic                     req_tlast,
   input  logic                     fifo_full,
   output logic                     fifo_wr_en,
   output item_type                 fifo_wr_item
);

   // A beat is taken whenever the queue has room; it is split into its two
   // values and tagged as a body or a closing item.
   assign req_tready = !fifo_full;
   assign fifo_wr_en = req_tvalid && !fifo_full;

   always_comb begin
      fifo_wr_item.push_value = req_tdata[VALUE_BITS-1:0];
      fifo_wr_item.pop_value  = req_tdata[2*VALUE_BITS-1:VALUE_BITS];
      fifo_wr_item.kind       = req_tlast ? ITEM_LAST : ITEM_BODY;
   end

endmodule

/* rtl/ssc_fifo.sv */
module ssc_fifo
   import ssc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          wr_en,
   input  item_type      wr_item,
   input  logic          rd_en,
   output fifo_head_type head,
   output logic          full
);

   item_type                 entries_ff [FIFO_DEPTH];
   logic [FIFO_IDX_BITS-1:0] wr_ptr_ff;
   logic [FIFO_IDX_BITS-1:0] wr_ptr_in;
   logic [FIFO_IDX_BITS-1:0] rd_ptr_ff;
   logic [FIFO_IDX_BITS-1:0] rd_ptr_in;
   logic [FIFO_CNT_BITS-1:0] count_ff;
   logic [FIFO_CNT_BITS-1:0] count_in;
   logic                     do_wr;
   logic                     do_rd;

   assign full  = (count_ff == FIFO_CNT_BITS'(FIFO_DEPTH));
   assign do_wr = wr_en && !full;
   assign do_rd = rd_en && (count_ff != '0);

   always_comb begin
      head.valid = (count_ff != '0);
      head.item  = entries_ff[rd_ptr_ff];
      wr_ptr_in  = do_wr ? wr_ptr_ff + FIFO_IDX_BITS'(1) : wr_ptr_ff;
      rd_ptr_in  = do_rd ? rd_ptr_ff + FIFO_IDX_BITS'(1) : rd_ptr_ff;
      count_in   = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + FIFO_CNT_BITS'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - FIFO_CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         entries_ff[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

/* rtl/ssc_back.sv */
module ssc_back
   import ssc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  fifo_head_type            head,
   output logic                     take,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata
);

   value_type      stack_store_ff [DEPTH];
   value_type      pop_queue_ff   [DEPTH];
   value_type      stack_rd_ff;
   value_type      queue_rd_ff;

   back_state_type state_ff;
   back_state_type state_in;
   cnt_type        count_ff;
   cnt_type        count_in;
   idx_type        head_idx_ff;
   idx_type        head_idx_in;
   idx_type        tail_idx_ff;
   idx_type        tail_idx_in;
   logic           overflow_ff;
   logic           overflow_in;
   logic           last_ff;
   logic           last_in;
   value_type      top_ff;
   value_type      top_in;
   value_type      head_val_ff;
   value_type      head_val_in;
   logic           from_mem_ff;
   logic           from_mem_in;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   result_type     rsp_data_ff;
   result_type     rsp_data_in;

   value_type      cur_top;
   value_type      cur_head;
   logic           match;
   logic           can_take;
   logic           push_en;
   logic           pop_en;
   cnt_type        below_top;
   idx_type        stack_rd_addr;
   idx_type        queue_rd_addr;

   // Right after a pop the new top and queue head come straight from the
   // memory read registers; otherwise from the cached copies.
   assign cur_top       = from_mem_ff ? stack_rd_ff : top_ff;
   assign cur_head      = from_mem_ff ? queue_rd_ff : head_val_ff;
   assign match         = (count_ff != '0) && (cur_top == cur_head);
   assign below_top     = count_ff - cnt_type'(2);
   assign stack_rd_addr = below_top[IDX_BITS-1:0];
   assign queue_rd_addr = ring_next(head_idx_ff);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'(rsp_data_ff);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      head_idx_in  = head_idx_ff;
      tail_idx_in  = tail_idx_ff;
      overflow_in  = overflow_ff;
      last_in      = last_ff;
      top_in       = cur_top;
      head_val_in  = cur_head;
      from_mem_in  = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      can_take     = 1'b0;
      take         = 1'b0;
      push_en      = 1'b0;
      pop_en       = 1'b0;

      case (state_ff)
         BACK_IDLE: begin
            can_take = 1'b1;
         end
         BACK_CHECK: begin
            if (match) begin
               pop_en      = 1'b1;
               count_in    = count_ff - cnt_type'(1);
               head_idx_in = ring_next(head_idx_ff);
               from_mem_in = 1'b1;
            end else if (last_ff) begin
               state_in = BACK_EMIT;
            end else begin
               state_in = BACK_IDLE;
               can_take = 1'b1;
            end
         end
         BACK_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.too_long       = overflow_ff;
               rsp_data_in.sequence_valid = !overflow_ff && (count_ff == '0);
               count_in                   = '0;
               head_idx_in                = '0;
               tail_idx_in                = '0;
               overflow_in                = 1'b0;
               last_in                    = 1'b0;
               state_in                   = BACK_IDLE;
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase

      if (can_take && head.valid) begin
         take = 1'b1;
         if (overflow_ff || (count_ff == FULL_CNT)) begin
            // Items past capacity are dropped until the sequence closes.
            overflow_in = 1'b1;
            state_in    = (head.item.kind == ITEM_LAST) ? BACK_EMIT : BACK_IDLE;
         end else begin
            push_en     = 1'b1;
            count_in    = count_ff + cnt_type'(1);
            tail_idx_in = ring_next(tail_idx_ff);
            top_in      = head.item.push_value;
            head_val_in = (count_ff == '0) ? head.item.pop_value : cur_head;
            last_in     = (head.item.kind == ITEM_LAST);
            state_in    = BACK_CHECK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         count_ff     <= '0;
         head_idx_ff  <= '0;
         tail_idx_ff  <= '0;
         overflow_ff  <= 1'b0;
         last_ff      <= 1'b0;
         from_mem_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         head_idx_ff  <= head_idx_in;
         tail_idx_ff  <= tail_idx_in;
         overflow_ff  <= overflow_in;
         last_ff      <= last_in;
         from_mem_ff  <= from_mem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff      <= top_in;
      head_val_ff <= head_val_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Stack and pop-order ring: one write and one registered read each.
   always_ff @(posedge clock) begin
      if (push_en) begin
         stack_store_ff[count_ff[IDX_BITS-1:0]] <= head.item.push_value;
         pop_queue_ff[tail_idx_ff]              <= head.item.pop_value;
      end
      if (pop_en) begin
         stack_rd_ff <= stack_store_ff[stack_rd_addr];
         queue_rd_ff <= pop_queue_ff[queue_rd_addr];
      end
   end

endmodule

/* rtl/stack_sequence_checker.sv */
// Channel   Direction  Ports                                 Payload
// req       in         req_tvalid req_tready req_tdata       push_value, pop_value
//                      req_tlast                             last_item
// rsp       out        rsp_tvalid rsp_tready rsp_tdata       sequence_valid, too_long
//
// Each item is pushed in the back end as it is taken, and every matching pop
// that follows it is done in turn before the next item is taken; the pop loop
// through the stack and ring memories paces a sustained stream.
// A closing item passes through BACK_EMIT, which forms the result, and back to
// BACK_IDLE before the next item is taken (an overflowed sequence skips BACK_CHECK).
// Reset is synchronous and active high; it empties the queue, the stack count
// and the ring pointers, and needs no pass over the memories.
// A stalled result waits in its output register while the front keeps taking
// beats into a four-entry queue; the back end holds only when it must emit.
module stack_sequence_checker
   import ssc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // req_tdata, low bit up: push_value[15:0], pop_value[31:16]
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   input  logic                     req_tlast,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // rsp_tdata, low bit up: sequence_valid[0], too_long[1], zeros[7:2]
   output logic [RSP_DATA_BITS-1:0] rsp_tdata
);

   // The front splits and tags each beat, the queue decouples it from the
   // back end, and the back end runs the push and pop-match loop over the
   // stack memory and the ring of popped values.
   logic          fifo_full;
   logic          fifo_wr_en;
   item_type      fifo_wr_item;
   fifo_head_type fifo_head;
   logic          fifo_take;

   ssc_front u_front (
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tlast    (req_tlast),
      .fifo_full    (fifo_full),
      .fifo_wr_en   (fifo_wr_en),
      .fifo_wr_item (fifo_wr_item)
   );

   ssc_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (fifo_wr_en),
      .wr_item (fifo_wr_item),
      .rd_en   (fifo_take),
      .head    (fifo_head),
      .full    (fifo_full)
   );

   // The back end keeps the top of stack and the head of the ring in
   // registers so each comparison needs no memory access in the same cycle.
   ssc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (fifo_head),
      .take       (fifo_take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

/* rtl/ssc_checker.sv */
module ssc_checker
   import ssc_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_tvalid,
   input logic                     rsp_tready,
   input logic [RSP_DATA_BITS-1:0] rsp_tdata
);

   // A result that is not taken stays offered and unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed or dropped while stalled");

   // An overflowed sequence can never be reported as valid.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[1]))
      else $error("result both valid and too long");

   // The padding bits of a result are always zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[RSP_DATA_BITS-1:2] == '0))
      else $error("result padding not zero");

   // No result is offered in the cycle after reset.
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid)
      else $error("result offered straight out of reset");

endmodule

bind stack_sequence_checker ssc_checker u_checker (.*);
